FILE: rtl/tmcp_pkg.sv
// ----------------------------------------------------------------------------
// tmcp_pkg
// Shared types and constants of the color-tag text markup parser: the stack
// geometry, the work item passed from the parser front to the event back end.
// ----------------------------------------------------------------------------
package tmcp_pkg;

    localparam int STACK_DEPTH   = 32;
    localparam int STACK_ENTRIES = STACK_DEPTH - 1;
    localparam int LEVEL_W       = $clog2(STACK_DEPTH);
    localparam int STACK_ADDR_W  = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(STACK_ENTRIES);
    localparam logic [LEVEL_W-1:0] TOP_ENTRY = LEVEL_W'(STACK_ENTRIES - 1);

    localparam int COLOR_W = 32;
    localparam int CP_W    = 16;
    localparam int HEX_W   = 24;

    localparam logic [COLOR_W-HEX_W-1:0] COLOR_ALPHA     = '1;
    localparam logic [COLOR_W-1:0]       BASE_COLOR_INIT = '1;

    localparam int MAX_RESULTS = 3;
    localparam int COUNT_W     = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_BREAK = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_CLEAR
    } stack_op_t;

    typedef struct packed {
        logic            kind;
        logic [CP_W-1:0] code_point;
    } result_t;

    // One accepted byte's worth of work for the back end.
    typedef struct packed {
        stack_op_t                    op;
        logic [HEX_W-1:0]             push_value;
        logic [COUNT_W-1:0]           count;
        result_t [MAX_RESULTS-1:0]    slots;
    } work_t;

endpackage

FILE: rtl/text_markup_color_tag_parser_unit.sv
// ----------------------------------------------------------------------------
// text_markup_color_tag_parser_unit
// Color-tag markup parser: text bytes in, glyph and line-break events out.
// ----------------------------------------------------------------------------
// Feed the text one byte per item on the s_ channel, with s_tlast on the final
// byte of a string. The unit accepts one byte per cycle while the queue has
// room; each byte gives zero to three events, and the back end sends one event
// per cycle from its single output register while m_tready is high. A byte
// that only opens or closes a color tag is retired without using the output.
// Bytes that produce nothing and touch no color are absorbed by the parser
// alone. A four-item queue decouples the parser from the event side, so input
// keeps flowing while m_tready is low until the queue fills. Each event carries
// the color on top of the stack when its byte arrived; \c[ followed by seven
// body bytes pushes 0xFF000000 | (leading hex digits), \ce pops, and level zero
// shows base_color. The stack entries need no clearing after reset. Write
// base_color through the cfg_ channel only while the unit is idle.
// ----------------------------------------------------------------------------
module text_markup_color_tag_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: base_color
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    // text bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // end_of_text

    // events
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] code_point, [47:16] glyph_color
    output logic [0:0]  m_tuser,    // [0] event_kind (0 glyph, 1 line break)
    output logic        m_tlast     // last_of_run
);
    import tmcp_pkg::*;

    logic  fq_push;
    work_t fq_data;
    logic  fq_full;
    logic  fq_pop;
    logic  fq_valid;
    work_t fq_head;

    // Parse bytes into work items.
    tmcp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (fq_push),
        .q_data   (fq_data),
        .q_full   (fq_full)
    );

    // Hold work items until the event side can take them.
    tmcp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fq_push),
        .push_data  (fq_data),
        .full       (fq_full),
        .pop        (fq_pop),
        .head_valid (fq_valid),
        .head_data  (fq_head)
    );

    // Send events and advance the color stack.
    tmcp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (fq_valid),
        .q_head    (fq_head),
        .q_pop     (fq_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: rtl/tmcp_ram.sv
// ----------------------------------------------------------------------------
// tmcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tmcp_front.sv
// ----------------------------------------------------------------------------
// tmcp_front
// Byte parser: tracks escape, tag and UTF-8 state, and turns each accepted
// byte into a work item holding its events and its stack operation.
// ----------------------------------------------------------------------------
module tmcp_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,     // [7:0] text_byte
    input  logic           s_tlast,     // end_of_text
    output logic           q_push,
    output tmcp_pkg::work_t q_data,
    input  logic           q_full
);
    import tmcp_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BSL,
        MODE_BSL_C,
        MODE_TAG,
        MODE_UTF8
    } mode_t;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_C         = 8'h63;
    localparam logic [7:0] CHAR_E         = 8'h65;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [2:0] HEX_DIGITS_MAX = 3'd6;
    localparam logic [2:0] TAG_LAST_BYTE  = 3'd6;

    mode_t             mode_reg, mode_next;
    logic [2:0]        skip_reg, skip_next;
    logic [HEX_W-1:0]  hex_reg, hex_next;
    logic              stop_reg, stop_next;
    logic [CP_W-1:0]   u8v_reg, u8v_next;
    logic [1:0]        u8r_reg, u8r_next;

    logic              accept;
    logic              fresh_en;
    logic [1:0]        u8r_dec;
    logic [CP_W-1:0]   u8v_merged;
    work_t             work;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
                 (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b >= 8'h61) begin
            v = b - 8'h57;
        end else begin
            v = b - 8'h37;
        end
        hex_val = v[3:0];
    endfunction

    function automatic work_t add_result(input work_t w, input logic kind,
                                         input logic [CP_W-1:0] cp);
        work_t r;
        r = w;
        case (w.count)
            2'd0:    r.slots[0] = '{kind: kind, code_point: cp};
            2'd1:    r.slots[1] = '{kind: kind, code_point: cp};
            default: r.slots[2] = '{kind: kind, code_point: cp};
        endcase
        r.count = w.count + COUNT_W'(1);
        add_result = r;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        mode_next  = mode_reg;
        skip_next  = skip_reg;
        hex_next   = hex_reg;
        stop_next  = stop_reg;
        u8v_next   = u8v_reg;
        u8r_next   = u8r_reg;
        fresh_en   = 1'b0;
        u8r_dec    = u8r_reg;
        u8v_merged = u8v_reg;
        work       = '0;
        work.op    = OP_NONE;

        case (mode_reg)
            MODE_BSL: begin
                if (s_tdata == CHAR_C) begin
                    mode_next = MODE_BSL_C;
                end else begin
                    work     = add_result(work, KIND_GLYPH, CP_W'(CHAR_BACKSLASH));
                    fresh_en = 1'b1;
                end
            end
            MODE_BSL_C: begin
                if (s_tdata == CHAR_LBRACKET) begin
                    mode_next = MODE_TAG;
                    skip_next = '0;
                    hex_next  = '0;
                    stop_next = 1'b0;
                end else if (s_tdata == CHAR_E) begin
                    mode_next = MODE_IDLE;
                    work.op   = OP_POP;
                end else begin
                    work     = add_result(work, KIND_GLYPH, CP_W'(CHAR_BACKSLASH));
                    work     = add_result(work, KIND_GLYPH, CP_W'(CHAR_C));
                    fresh_en = 1'b1;
                end
            end
            MODE_TAG: begin
                if (skip_reg < HEX_DIGITS_MAX && !stop_reg) begin
                    if (is_hex(s_tdata)) begin
                        hex_next = {hex_reg[HEX_W-5:0], hex_val(s_tdata)};
                    end else begin
                        stop_next = 1'b1;
                    end
                end
                skip_next = skip_reg + 3'd1;
                if (skip_reg >= TAG_LAST_BYTE) begin
                    work.op         = OP_PUSH;
                    work.push_value = hex_next;
                    mode_next       = MODE_IDLE;
                    skip_next       = '0;
                    hex_next        = '0;
                    stop_next       = 1'b0;
                end
            end
            MODE_UTF8: begin
                if (u8r_reg != 2'd0) begin
                    u8r_dec = u8r_reg - 2'd1;
                    if (u8r_dec == 2'd1) begin
                        u8v_merged = u8v_reg | {4'd0, s_tdata[5:0], 6'd0};
                    end else begin
                        u8v_merged = u8v_reg | {10'd0, s_tdata[5:0]};
                    end
                end
                u8r_next = u8r_dec;
                u8v_next = u8v_merged;
                if (u8r_dec == 2'd0) begin
                    mode_next = MODE_IDLE;
                    work      = add_result(work, KIND_GLYPH, u8v_merged);
                    u8v_next  = '0;
                end
            end
            default: begin
                fresh_en = 1'b1;
            end
        endcase

        // Start a new character from this byte.
        if (fresh_en) begin
            mode_next = MODE_IDLE;
            if (s_tdata == CHAR_NEWLINE) begin
                work = add_result(work, KIND_BREAK, '0);
            end else if (s_tdata == CHAR_BACKSLASH) begin
                mode_next = MODE_BSL;
            end else if ((s_tdata & 8'hE0) == 8'hC0) begin
                u8v_next  = {5'd0, s_tdata[4:0], 6'd0};
                u8r_next  = 2'd1;
                mode_next = MODE_UTF8;
            end else if ((s_tdata & 8'hF0) == 8'hE0) begin
                u8v_next  = {s_tdata[3:0], 12'd0};
                u8r_next  = 2'd2;
                mode_next = MODE_UTF8;
            end else begin
                work = add_result(work, KIND_GLYPH, CP_W'(s_tdata));
            end
        end

        // Flush pending bytes, drop an open tag, reset everything.
        if (s_tlast) begin
            case (mode_next)
                MODE_BSL: begin
                    work = add_result(work, KIND_GLYPH, CP_W'(CHAR_BACKSLASH));
                end
                MODE_BSL_C: begin
                    work = add_result(work, KIND_GLYPH, CP_W'(CHAR_BACKSLASH));
                    work = add_result(work, KIND_GLYPH, CP_W'(CHAR_C));
                end
                MODE_UTF8: begin
                    work = add_result(work, KIND_GLYPH, u8v_next);
                end
                default: begin
                end
            endcase
            mode_next = MODE_IDLE;
            skip_next = '0;
            hex_next  = '0;
            stop_next = 1'b0;
            u8v_next  = '0;
            u8r_next  = '0;
            work.op   = OP_CLEAR;
        end
    end

    assign q_push = accept && (work.count != '0 || work.op != OP_NONE);
    assign q_data = work;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            skip_reg <= '0;
            hex_reg  <= '0;
            stop_reg <= 1'b0;
            u8v_reg  <= '0;
            u8r_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
            hex_reg  <= hex_next;
            stop_reg <= stop_next;
            u8v_reg  <= u8v_next;
            u8r_reg  <= u8r_next;
        end
    end

endmodule

FILE: rtl/tmcp_queue.sv
// ----------------------------------------------------------------------------
// tmcp_queue
// Short work queue between the parser front and the event back end.
// ----------------------------------------------------------------------------
module tmcp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tmcp_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output tmcp_pkg::work_t head_data
);
    import tmcp_pkg::*;

    work_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg, fill_next;
    logic                   do_push, do_pop;

    assign full       = (fill_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (QUEUE_PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/tmcp_back.sv
// ----------------------------------------------------------------------------
// tmcp_back
// Event back end: owns the color stack and the base color register, sends the
// item events one per cycle while the output is free, then applies its stack operation.
// ----------------------------------------------------------------------------
module tmcp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_data,
    input  logic            q_valid,
    input  tmcp_pkg::work_t q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [47:0]     m_tdata,    // [15:0] code_point, [47:16] glyph_color
    output logic [0:0]      m_tuser,    // [0] event_kind
    output logic            m_tlast     // last_of_run
);
    import tmcp_pkg::*;

    logic [COLOR_W-1:0]      base_color_reg;
    logic [LEVEL_W-1:0]      level_reg, level_next;
    logic [COLOR_W-1:0]      top_reg, top_next;
    logic [COUNT_W-1:0]      idx_reg, idx_next;

    logic                    m_valid_reg;
    logic [CP_W-1:0]         m_cp_reg;
    logic [COLOR_W-1:0]      m_color_reg;
    logic                    m_kind_reg;
    logic                    m_last_reg;

    logic                    out_free;
    logic                    emit_en;
    logic                    count_last;
    result_t                 head_slot;
    logic [COLOR_W-1:0]      cur_color;

    logic                    wr_en;
    logic [STACK_ADDR_W-1:0] wr_addr;
    logic [COLOR_W-1:0]      wr_data;
    logic [LEVEL_W-1:0]      rd_level;
    logic [STACK_ADDR_W-1:0] rd_addr;
    logic [COLOR_W-1:0]      rd_data;

    // Stack entries, top included; read address tracks the entry under the new top.
    tmcp_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STACK_ENTRIES)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign cur_color = (level_reg == '0) ? base_color_reg : top_reg;

    always_comb begin
        case (idx_reg)
            2'd1:    head_slot = q_head.slots[1];
            2'd2:    head_slot = q_head.slots[2];
            default: head_slot = q_head.slots[0];
        endcase
        count_last = (idx_reg == q_head.count - COUNT_W'(1));
        emit_en    = q_valid && (q_head.count != '0) && out_free;
        q_pop      = q_valid && ((q_head.count == '0) || (emit_en && count_last));

        idx_next = idx_reg;
        if (emit_en) begin
            idx_next = count_last ? '0 : idx_reg + COUNT_W'(1);
        end

        level_next = level_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        wr_addr    = level_reg[STACK_ADDR_W-1:0];
        wr_data    = {COLOR_ALPHA, q_head.push_value};
        if (q_pop) begin
            case (q_head.op)
                OP_PUSH: begin
                    wr_en    = 1'b1;
                    top_next = wr_data;
                    if (level_reg < MAX_LEVEL) begin
                        level_next = level_reg + LEVEL_W'(1);
                    end else begin
                        wr_addr = TOP_ENTRY[STACK_ADDR_W-1:0];
                    end
                end
                OP_POP: begin
                    if (level_reg != '0) begin
                        level_next = level_reg - LEVEL_W'(1);
                        top_next   = rd_data;
                    end
                end
                OP_CLEAR: begin
                    level_next = '0;
                end
                default: begin
                end
            endcase
        end

        rd_level = level_next - LEVEL_W'(2);
        rd_addr  = rd_level[STACK_ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (emit_en) begin
            m_cp_reg    <= head_slot.code_point;
            m_kind_reg  <= head_slot.kind;
            m_color_reg <= cur_color;
            m_last_reg  <= count_last;
        end
        top_reg <= top_next;
        if (!aresetn) begin
            base_color_reg <= BASE_COLOR_INIT;
            level_reg      <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_color_reg <= cfg_data;
            end
            level_reg <= level_next;
            idx_reg   <= idx_next;
            if (emit_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {m_color_reg, m_cp_reg};
    assign m_tuser[0] = m_kind_reg;
    assign m_tlast    = m_last_reg;

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.op == OP_CLEAR) |=> (level_reg == '0))
        else $error("stack level not zero after clear");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.op == OP_PUSH && level_reg < MAX_LEVEL)
        |=> (level_reg == $past(level_reg) + LEVEL_W'(1)))
        else $error("push below full did not raise the level");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && idx_reg != '0) |-> (idx_reg < q_head.count))
        else $error("event slot index beyond item event count");

    a_last_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_en && count_last) |-> q_pop)
        else $error("last event sent without retiring its item");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_en |=> (m_valid_reg && m_last_reg == $past(count_last)))
        else $error("loaded event not presented");

endmodule

FILE: sim/tb_text_markup_color_tag_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_markup_color_tag_parser_unit
// Self-checking bench for the color-tag text parser. A scoreboard model of
// the parse state and color stack predicts the glyph and line-break events
// for each byte accepted on the s_ channel. Each event taken from m_ is
// compared field by field against the oldest prediction. Three phases run
// with different base colors and idle patterns. The last phase backs up the
// input with a burst of glyphs while the event side is held off, then pushes
// and pops a run of colors.
// ----------------------------------------------------------------------------
module tb_text_markup_color_tag_parser_unit;

    import tmcp_pkg::*;

    localparam int SETTLE_CYCLES = 16;     // back end may still hold a color-only byte
    localparam int HOLD_CYCLES   = 64;     // event side held off to back up the input
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam int RANDOM_BYTES  = 22;     // per phase
    localparam int HOLD_GLYPHS   = 16;     // plain glyphs offered during the hold-off
    localparam int FILL_PUSHES   = 4;

    // Characters that steer the parser.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_C         = 8'h63;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_OPEN      = 8'h5B;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;

    localparam logic [31:0] OPAQUE_ALPHA = 32'hFF00_0000;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_BACKSLASH,
        SCAN_BACKSLASH_C,
        SCAN_TAG_BODY,
        SCAN_MULTIBYTE
    } scan_state_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] code_point;
        logic [31:0] color;
        logic        last;
    } text_event_t;

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
    } text_item_t;

    // Directed row: byte, end flag, and optionally the single event it must give.
    typedef struct packed {
        logic [7:0]  text;
        logic        eot;
        logic        typed;
        logic        kind;
        logic [15:0] code_point;
        logic [31:0] color;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    text_markup_color_tag_parser_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Scoreboard model of the parser
    // ------------------------------------------------------------------
    scan_state_t        scan_state;
    logic [2:0]         body_count;
    logic [23:0]        tag_hex;
    logic               tag_hex_done;
    logic [15:0]        char_acc;
    logic [1:0]         char_left;
    logic [31:0]        color_stack [STACK_ENTRIES];
    logic [LEVEL_W-1:0] color_level;
    logic [31:0]        base_color_reg;

    text_event_t byte_events[$];      // events of the byte just accepted
    text_event_t pending_events[$];   // events still owed by the block

    text_item_t  text_q[$];
    logic [7:0]  token_bytes[$];

    int unsigned error_count;
    int unsigned row_error_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_armed;
    logic        rx_hold;
    text_event_t rx_want;

    // Level zero shows the base color; otherwise the newest pushed entry.
    function automatic logic [31:0] top_color();
        return (color_level == '0) ? base_color_reg : color_stack[color_level - 1'b1];
    endfunction

    function automatic void add_event(input logic kind, input logic [15:0] cp);
        byte_events.push_back('{kind, cp, top_color(), 1'b0});
    endfunction

    // Handle a byte with no pending sequence in front of it.
    function automatic void start_char(input logic [7:0] b);
        if (b == CH_NEWLINE) begin
            add_event(KIND_BREAK, 16'h0000);
        end else if (b == CH_BACKSLASH) begin
            scan_state = SCAN_BACKSLASH;
        end else if ((b & 8'hE0) == 8'hC0) begin
            char_acc   = {5'b0, b[4:0], 6'b0};
            char_left  = 2'd1;
            scan_state = SCAN_MULTIBYTE;
        end else if ((b & 8'hF0) == 8'hE0) begin
            char_acc   = {b[3:0], 12'b0};
            char_left  = 2'd2;
            scan_state = SCAN_MULTIBYTE;
        end else begin
            add_event(KIND_GLYPH, {8'h00, b});
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic eot);
        logic [3:0] nib;
        logic       is_digit;

        byte_events.delete();
        case (scan_state)
            SCAN_BACKSLASH: begin
                if (b == CH_C) begin
                    scan_state = SCAN_BACKSLASH_C;
                end else begin
                    scan_state = SCAN_IDLE;
                    add_event(KIND_GLYPH, {8'h00, CH_BACKSLASH});
                    start_char(b);
                end
            end
            SCAN_BACKSLASH_C: begin
                if (b == CH_OPEN) begin
                    scan_state   = SCAN_TAG_BODY;
                    body_count   = '0;
                    tag_hex      = '0;
                    tag_hex_done = 1'b0;
                end else if (b == CH_E) begin
                    scan_state = SCAN_IDLE;
                    if (color_level != '0)
                        color_level = color_level - 1'b1;
                end else begin
                    scan_state = SCAN_IDLE;
                    add_event(KIND_GLYPH, {8'h00, CH_BACKSLASH});
                    add_event(KIND_GLYPH, {8'h00, CH_C});
                    start_char(b);
                end
            end
            SCAN_TAG_BODY: begin
                if (body_count < 3'd6 && !tag_hex_done) begin
                    is_digit = 1'b1;
                    nib      = '0;
                    if (b >= CH_0 && b <= CH_9)
                        nib = 4'(b - CH_0);
                    else if (b >= CH_LA && b <= CH_LF)
                        nib = 4'(b - CH_LA + 8'd10);
                    else if (b >= CH_UA && b <= CH_UF)
                        nib = 4'(b - CH_UA + 8'd10);
                    else
                        is_digit = 1'b0;
                    if (is_digit)
                        tag_hex = {tag_hex[19:0], nib};
                    else
                        tag_hex_done = 1'b1;
                end
                body_count = body_count + 1'b1;
                if (body_count == 3'd7) begin
                    // A full stack overwrites its top entry instead of growing.
                    if (color_level < MAX_LEVEL) begin
                        color_stack[color_level] = OPAQUE_ALPHA | {8'h00, tag_hex};
                        color_level = color_level + 1'b1;
                    end else begin
                        color_stack[MAX_LEVEL - 1'b1] = OPAQUE_ALPHA | {8'h00, tag_hex};
                    end
                    scan_state   = SCAN_IDLE;
                    body_count   = '0;
                    tag_hex      = '0;
                    tag_hex_done = 1'b0;
                end
            end
            SCAN_MULTIBYTE: begin
                // Continuation bytes are taken whatever their top bits are.
                if (char_left != '0) begin
                    char_left = char_left - 1'b1;
                    char_acc  = char_acc | (16'(b[5:0]) << (6 * char_left));
                end
                if (char_left == '0) begin
                    scan_state = SCAN_IDLE;
                    add_event(KIND_GLYPH, char_acc);
                    char_acc = '0;
                end
            end
            default: begin
                scan_state = SCAN_IDLE;
                start_char(b);
            end
        endcase

        // End of string: flush what is pending, drop an open tag, clear the stack.
        if (eot) begin
            if (scan_state == SCAN_BACKSLASH) begin
                add_event(KIND_GLYPH, {8'h00, CH_BACKSLASH});
            end else if (scan_state == SCAN_BACKSLASH_C) begin
                add_event(KIND_GLYPH, {8'h00, CH_BACKSLASH});
                add_event(KIND_GLYPH, {8'h00, CH_C});
            end else if (scan_state == SCAN_MULTIBYTE) begin
                add_event(KIND_GLYPH, char_acc);
            end
            scan_state   = SCAN_IDLE;
            body_count   = '0;
            tag_hex      = '0;
            tag_hex_done = 1'b0;
            char_acc     = '0;
            char_left    = '0;
            color_level  = '0;
        end

        if (byte_events.size() != 0)
            byte_events[byte_events.size() - 1].last = 1'b1;
        foreach (byte_events[i])
            pending_events.push_back(byte_events[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    // Append one color tag: \c[ then seven body bytes, mostly hex digits.
    function automatic void queue_push_tag();
        int unsigned r;

        token_bytes.push_back(CH_BACKSLASH);
        token_bytes.push_back(CH_C);
        token_bytes.push_back(CH_OPEN);
        for (int i = 0; i < 7; i++) begin
            r = $urandom_range(0, 21);
            if ($urandom_range(0, 9) < 2 || i == 6)
                token_bytes.push_back(8'($urandom_range(0, 255)));
            else if (r < 10)
                token_bytes.push_back(CH_0 + 8'(r));
            else if (r < 16)
                token_bytes.push_back(CH_LA + 8'(r - 10));
            else
                token_bytes.push_back(CH_UA + 8'(r - 16));
        end
    endfunction

    // Move the token into the send queue, end flag on byte index cut (-1: none).
    function automatic void flush_token(input int cut);
        foreach (token_bytes[i])
            text_q.push_back('{token_bytes[i], (i == cut)});
        token_bytes.delete();
    endfunction

    // One random token: mostly well-formed sequences, some noise and cut strings.
    function automatic void queue_token();
        int unsigned r;
        logic [7:0]  b;
        int          cut;

        r = $urandom_range(0, 99);
        if (r < 30) begin
            do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CH_BACKSLASH);
            token_bytes.push_back(b);
        end else if (r < 38) begin
            token_bytes.push_back(CH_NEWLINE);
        end else if (r < 56) begin
            // two- or three-byte character, continuations occasionally malformed
            if (r < 48)
                token_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            else
                token_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            repeat ((r < 48) ? 1 : 2) begin
                if ($urandom_range(0, 9) == 0)
                    token_bytes.push_back(8'($urandom_range(0, 255)));
                else
                    token_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
        end else if (r < 70) begin
            queue_push_tag();
        end else if (r < 80) begin
            token_bytes.push_back(CH_BACKSLASH);
            token_bytes.push_back(CH_C);
            token_bytes.push_back(CH_E);
        end else if (r < 85) begin
            // lone backslash
            token_bytes.push_back(CH_BACKSLASH);
            do b = 8'($urandom_range(0, 255)); while (b == CH_C);
            token_bytes.push_back(b);
        end else if (r < 90) begin
            // backslash, c, then something that is no tag
            token_bytes.push_back(CH_BACKSLASH);
            token_bytes.push_back(CH_C);
            do b = 8'($urandom_range(0, 255)); while (b == CH_OPEN || b == CH_E);
            token_bytes.push_back(b);
        end else begin
            token_bytes.push_back(8'($urandom_range(0, 255)));
        end

        r = $urandom_range(0, 19);
        if (r == 0)
            cut = $urandom_range(0, token_bytes.size() - 1);
        else if (r < 3)
            cut = token_bytes.size() - 1;
        else
            cut = -1;
        flush_token(cut);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    // Offer one byte, idling first at the phase's rate; predict on acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_byte(b, eot);
    endtask

    task automatic send_text();
        text_item_t item;

        while (text_q.size() != 0) begin
            item = text_q.pop_front();
            send_byte(item.text, item.eot);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_base_color(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid      <= 1'b0;
        base_color_reg  = value;
    endtask

    // Wait for every owed event, then give a color-only byte time to retire.
    task automatic drain_events();
        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Event side: random ready, compare each accepted event with the oldest
    // prediction. rx_hold forces a long stall during the last phase.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d code_point %h color %h last %0d",
                       m_tuser[0], m_tdata[15:0], m_tdata[47:16], m_tlast);
                error_count++;
            end else begin
                rx_want = pending_events.pop_front();
                if (m_tuser[0] !== rx_want.kind) begin
                    $error("event_kind: expected %0d, got %0d", rx_want.kind, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[15:0] !== rx_want.code_point) begin
                    $error("code_point: expected %h, got %h",
                           rx_want.code_point, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[47:16] !== rx_want.color) begin
                    $error("glyph_color: expected %h, got %h", rx_want.color, m_tdata[47:16]);
                    error_count++;
                end
                if (m_tlast !== rx_want.last) begin
                    $error("last_of_run: expected %0d, got %0d", rx_want.last, m_tlast);
                    error_count++;
                end
            end
        end
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Long hold-off of the event side, counted here in cycles.
    initial begin
        rx_hold = 1'b0;
        wait (hold_armed);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Hard stop if the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_text_markup_color_tag_parser_unit: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directed rows: extremes, every kind of sequence, the special cases.
    // Rows with a typed event are read straight off the rules; the rest
    // rely on the scoreboard model.
    // ------------------------------------------------------------------
    directed_row_t directed_rows [26] = '{
        // plain glyph at the reset base color
        '{8'h41, 1'b0, 1'b1, KIND_GLYPH, 16'h0041, 32'hFFFF_FFFF},
        // zero byte is an ordinary glyph
        '{8'h00, 1'b0, 1'b1, KIND_GLYPH, 16'h0000, 32'hFFFF_FFFF},
        // stray high byte comes out as itself
        '{8'hFF, 1'b0, 1'b1, KIND_GLYPH, 16'h00FF, 32'hFFFF_FFFF},
        // lone backslash, then a fresh byte
        '{8'h5C, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h78, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        // backslash c with no tag: three glyphs from one byte
        '{8'h5C, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h63, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h5A, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        // pop on an empty stack
        '{8'h5C, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h63, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h65, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        // tag whose body holds a newline and a backslash; digits stop at the newline
        '{8'h5C, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h63, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h5B, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h31, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h46, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h0A, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h5C, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h61, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h62, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'h63, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        // glyph in the pushed color
        '{8'h41, 1'b0, 1'b1, KIND_GLYPH, 16'h0041, 32'hFF00_001F},
        // two-byte character
        '{8'hC3, 1'b0, 1'b0, KIND_GLYPH, 16'h0000, 32'h0},
        '{8'hA9, 1'b0, 1'b1, KIND_GLYPH, 16'h00E9, 32'hFF00_001F},
        // end of text inside a three-byte character: missing bits are zero
        '{8'hE2, 1'b1, 1'b1, KIND_GLYPH, 16'h2000, 32'hFF00_001F},
        // end of text right after a backslash
        '{8'h5C, 1'b1, 1'b1, KIND_GLYPH, 16'h005C, 32'hFFFF_FFFF}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        text_event_t row_evt;
        text_event_t row_got;

        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        hold_armed      = 1'b0;
        error_count     = 0;
        row_error_count = 0;
        send_idle_pct   = 37;
        recv_idle_pct   = 83;

        scan_state     = SCAN_IDLE;
        body_count     = '0;
        tag_hex        = '0;
        tag_hex_done   = 1'b0;
        char_acc       = '0;
        char_left      = '0;
        color_level    = '0;
        base_color_reg = BASE_COLOR_INIT;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase 1: sender idles sometimes, receiver mostly. All-ones base color.
        write_base_color(32'hFFFF_FFFF);
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].text, directed_rows[i].eot);
            if (directed_rows[i].typed) begin
                row_evt = '{directed_rows[i].kind, directed_rows[i].code_point,
                            directed_rows[i].color, 1'b1};
                row_got = '0;
                if (byte_events.size() != 0)
                    row_got = byte_events[0];
                if (byte_events.size() != 1 || row_got !== row_evt) begin
                    $error({"directed row %0d: expected kind %0d code_point %h color %h, ",
                            "got kind %0d code_point %h color %h in %0d events"},
                           i, row_evt.kind, row_evt.code_point, row_evt.color,
                           row_got.kind, row_got.code_point, row_got.color,
                           byte_events.size());
                    row_error_count++;
                end
            end
        end
        while (text_q.size() < RANDOM_BYTES)
            queue_token();
        send_text();
        drain_events();

        // Phase 2: roles swapped, all-zeros base color.
        send_idle_pct = 83;
        recv_idle_pct = 37;
        write_base_color(32'h0000_0000);
        while (text_q.size() < RANDOM_BYTES)
            queue_token();
        send_text();
        drain_events();

        // Phase 3: no idling, random base color, then a glyph burst while the
        // event side is held off so the input backs up, then a run of colors.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_base_color($urandom);
        while (text_q.size() < RANDOM_BYTES)
            queue_token();
        // close the random string so the pushes start from level zero
        text_q.push_back('{8'h41, 1'b1});
        send_text();
        @(posedge aclk);

        hold_armed = 1'b1;
        for (int i = 0; i < HOLD_GLYPHS; i++)
            text_q.push_back('{8'h61 + 8'(i), 1'b0});
        repeat (FILL_PUSHES) begin
            queue_push_tag();
            flush_token(-1);
        end
        text_q.push_back('{8'h41, 1'b0});
        repeat (3) begin
            text_q.push_back('{CH_BACKSLASH, 1'b0});
            text_q.push_back('{CH_C, 1'b0});
            text_q.push_back('{CH_E, 1'b0});
        end
        text_q.push_back('{8'h42, 1'b0});
        text_q.push_back('{CH_NEWLINE, 1'b1});
        send_text();
        drain_events();

        if (error_count == 0 && row_error_count == 0)
            $display("tb_text_markup_color_tag_parser_unit: PASS");
        else
            $display("tb_text_markup_color_tag_parser_unit: FAIL");
        $finish;
    end

endmodule
